[src/ffba_pkg.sv]
// Package with the shared types, constants and codes of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned HeapWords = 1024;
  localparam int unsigned AddrW     = $clog2(HeapWords);
  localparam int unsigned DataW     = 16;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ReqW      = 12;
  localparam int unsigned PtrW      = 10;
  localparam int unsigned CfgW      = 12;
  localparam int unsigned WideW     = 17;
  localparam int unsigned LenW      = ReqW + 1;
  localparam int unsigned MaxSteps  = 4 * HeapWords;
  localparam int unsigned StepCntW  = $clog2(MaxSteps + 1);

  localparam int unsigned HeaderOverhead = 12;
  localparam logic [DataW-1:0] SentinelHdr    = DataW'(5);
  localparam logic [CfgW-1:0]  HeapBytesReset = CfgW'(4080);
  localparam logic [WideW-1:0] CapBytes       = WideW'(((HeapWords * 4) / 8) * 8);

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_COALESCE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_FORMAT,
    ST_IDLE,
    ST_AL_DATA,
    ST_AL_SPLIT,
    ST_FR_DATA,
    ST_CO_HEAD,
    ST_CO_NEXT,
    ST_CO_DATA
  } state_e;

  typedef struct packed {
    logic             reformat;
    logic [AddrW-1:0] last_word;
    logic [DataW-1:0] free_bytes;
  } geom_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic            granted;
    logic [PtrW-1:0] payload_address;
  } result_t;

endpackage

[src/ffba_req_if.sv]
// Interface of the command channel of the allocator.
`timescale 1ns / 1ps

interface ffba_req_if;
  logic                           valid;
  logic                           ready;
  logic [ffba_pkg::CmdW-1:0]      cmd;
  logic [ffba_pkg::ReqW-1:0]      request_bytes;
  logic [ffba_pkg::PtrW-1:0]      block_address;

  modport source (output valid, output cmd, output request_bytes, output block_address,
                  input ready);
  modport sink (input valid, input cmd, input request_bytes, input block_address,
                output ready);
endinterface

[src/ffba_rsp_if.sv]
// Interface of the result channel of the allocator.
`timescale 1ns / 1ps

interface ffba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic [ffba_pkg::PtrW-1:0] payload_address;

  modport source (output valid, output granted, output payload_address, input ready);
  modport sink (input valid, input granted, input payload_address, output ready);
endinterface

[src/ffba_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ffba_engine.sv]
// Sequencer that formats the header store, walks it for allocate and coalesce, and marks a header free.
`timescale 1ns / 1ps

module ffba_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffba_pkg::geom_t               geom_i,
  ffba_req_if.sink                      req_i,
  output ffba_pkg::mem_req_t            mem_o,
  input  logic [ffba_pkg::DataW-1:0]    rdata_i,
  output logic                          res_valid_o,
  output ffba_pkg::result_t             res_o,
  input  logic                          res_ready_i
);

  ffba_pkg::state_e                  state_q, state_d;
  logic [ffba_pkg::AddrW-1:0]        w_q, w_d;
  logic [ffba_pkg::AddrW-1:0]        n_q, n_d;
  logic [ffba_pkg::DataW-1:0]        hw_q, hw_d;
  logic [ffba_pkg::LenW-1:0]         len_q, len_d;
  logic [ffba_pkg::DataW-1:0]        rest_q, rest_d;
  logic [ffba_pkg::WideW-1:0]        split_q, split_d;
  logic [ffba_pkg::StepCntW-1:0]     steps_q, steps_d;
  logic [ffba_pkg::AddrW-1:0]        clr_q, clr_d;
  logic                              res_valid_q, res_valid_d;
  ffba_pkg::result_t                 res_q, res_d;

  logic [ffba_pkg::LenW-1:0]         len_sum;
  logic [ffba_pkg::LenW-1:0]         req_len;
  logic [ffba_pkg::WideW-1:0]        al_next;
  logic [ffba_pkg::WideW-1:0]        co_next;
  logic [ffba_pkg::WideW-1:0]        free_addr;
  logic                              al_fit;
  logic [ffba_pkg::DataW-1:0]        merged;

  assign len_sum   = ffba_pkg::LenW'(req_i.request_bytes) + ffba_pkg::LenW'(11);
  assign req_len   = {len_sum[ffba_pkg::LenW-1:3], 3'b000};
  assign al_fit    = !rdata_i[0] && (rdata_i >= ffba_pkg::DataW'(len_q));
  assign al_next   = ffba_pkg::WideW'(w_q) + ffba_pkg::WideW'(rdata_i[ffba_pkg::DataW-1:2]);
  assign co_next   = ffba_pkg::WideW'(w_q) + ffba_pkg::WideW'(hw_q[ffba_pkg::DataW-1:2]);
  assign free_addr = ffba_pkg::WideW'(req_i.block_address);
  assign merged    = hw_q + rdata_i;

  assign req_i.ready = (state_q == ffba_pkg::ST_IDLE) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::ST_FORMAT;
      clr_q       <= '0;
      steps_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      steps_q     <= steps_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    n_q     <= n_d;
    hw_q    <= hw_d;
    len_q   <= len_d;
    rest_q  <= rest_d;
    split_q <= split_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    n_d         = n_q;
    hw_d        = hw_q;
    len_d       = len_q;
    rest_d      = rest_q;
    split_d     = split_q;
    steps_d     = steps_q;
    clr_d       = clr_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    mem_o       = '0;

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ffba_pkg::ST_FORMAT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        if (clr_q == ffba_pkg::AddrW'(1)) begin
          mem_o.wdata = geom_i.free_bytes;
        end else if (clr_q == geom_i.last_word) begin
          mem_o.wdata = ffba_pkg::SentinelHdr;
        end else begin
          mem_o.wdata = '0;
        end
        if (clr_q == ffba_pkg::AddrW'(ffba_pkg::HeapWords - 1)) begin
          state_d = ffba_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + ffba_pkg::AddrW'(1);
        end
      end
      ffba_pkg::ST_IDLE: begin
        if (req_i.valid && !res_valid_q) begin
          case (req_i.cmd)
            ffba_pkg::CMD_ALLOC: begin
              len_d = req_len;
              w_d   = ffba_pkg::AddrW'(1);
              if (ffba_pkg::WideW'(req_len) > ffba_pkg::WideW'(geom_i.free_bytes)) begin
                res_valid_d = 1'b1;
                res_d       = '0;
              end else begin
                mem_o.raddr = ffba_pkg::AddrW'(1);
                state_d     = ffba_pkg::ST_AL_DATA;
              end
            end
            ffba_pkg::CMD_FREE: begin
              if (free_addr != '0 && free_addr <= ffba_pkg::WideW'(ffba_pkg::HeapWords)) begin
                n_d         = ffba_pkg::AddrW'(free_addr - ffba_pkg::WideW'(1));
                mem_o.raddr = ffba_pkg::AddrW'(free_addr - ffba_pkg::WideW'(1));
                state_d     = ffba_pkg::ST_FR_DATA;
              end else begin
                res_valid_d         = 1'b1;
                res_d.granted         = 1'b1;
                res_d.payload_address = '0;
              end
            end
            ffba_pkg::CMD_COALESCE: begin
              w_d         = ffba_pkg::AddrW'(1);
              steps_d     = '0;
              mem_o.raddr = ffba_pkg::AddrW'(1);
              state_d     = ffba_pkg::ST_CO_HEAD;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = '0;
            end
          endcase
        end
      end
      ffba_pkg::ST_AL_DATA: begin
        if (al_fit) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = w_q;
          mem_o.wdata = ffba_pkg::DataW'(len_q) + ffba_pkg::DataW'(1);
          rest_d      = rdata_i - ffba_pkg::DataW'(len_q);
          split_d     = ffba_pkg::WideW'(w_q) + ffba_pkg::WideW'(len_q[ffba_pkg::LenW-1:2]);
          state_d     = ffba_pkg::ST_AL_SPLIT;
        end else if (rdata_i[ffba_pkg::DataW-1:2] == '0 ||
                     al_next >= ffba_pkg::WideW'(geom_i.last_word)) begin
          res_valid_d = 1'b1;
          res_d       = '0;
          state_d     = ffba_pkg::ST_IDLE;
        end else begin
          w_d         = ffba_pkg::AddrW'(al_next);
          mem_o.raddr = ffba_pkg::AddrW'(al_next);
        end
      end
      ffba_pkg::ST_AL_SPLIT: begin
        if (rest_q != '0 && split_q < ffba_pkg::WideW'(ffba_pkg::HeapWords)) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = ffba_pkg::AddrW'(split_q);
          mem_o.wdata = rest_q;
        end
        res_valid_d           = 1'b1;
        res_d.granted         = 1'b1;
        res_d.payload_address = ffba_pkg::PtrW'(ffba_pkg::WideW'(w_q) + ffba_pkg::WideW'(1));
        state_d               = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_FR_DATA: begin
        if (rdata_i[0]) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = n_q;
          mem_o.wdata = rdata_i - ffba_pkg::DataW'(1);
        end
        res_valid_d           = 1'b1;
        res_d.granted         = 1'b1;
        res_d.payload_address = '0;
        state_d               = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_CO_HEAD: begin
        hw_d    = rdata_i;
        state_d = ffba_pkg::ST_CO_NEXT;
      end
      ffba_pkg::ST_CO_NEXT: begin
        if (hw_q[ffba_pkg::DataW-1:2] == '0 ||
            co_next >= ffba_pkg::WideW'(geom_i.last_word) ||
            steps_q >= ffba_pkg::StepCntW'(ffba_pkg::MaxSteps)) begin
          res_valid_d           = 1'b1;
          res_d.granted         = 1'b1;
          res_d.payload_address = '0;
          state_d               = ffba_pkg::ST_IDLE;
        end else begin
          n_d         = ffba_pkg::AddrW'(co_next);
          mem_o.raddr = ffba_pkg::AddrW'(co_next);
          state_d     = ffba_pkg::ST_CO_DATA;
        end
      end
      ffba_pkg::ST_CO_DATA: begin
        if (!hw_q[0] && !rdata_i[0]) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = w_q;
          mem_o.wdata = merged;
          hw_d        = merged;
        end else begin
          w_d  = n_q;
          hw_d = rdata_i;
        end
        steps_d = steps_q + ffba_pkg::StepCntW'(1);
        state_d = ffba_pkg::ST_CO_NEXT;
      end
      default: begin
        state_d = ffba_pkg::ST_IDLE;
      end
    endcase

    if (geom_i.reformat) begin
      state_d = ffba_pkg::ST_FORMAT;
      clr_d   = '0;
    end
  end

endmodule

[src/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: heap size register, header store and result register.
// The block keeps an implicit list of block headers in a 1024-word store. Commands arrive
// on the req_i channel (allocate, free, coalesce) and exactly one transaction leaves on
// the rsp_o channel for each command: granted and the payload word index of an allocation.
// Only one command is in progress at a time; req_i is ready again once the result has
// been handed to the output register.
// Free reads the block header and then clears its used bit; a rejected command is answered
// from idle. Allocate walks the block headers from word 1, one store read per header, and
// then writes the split-off remainder header. Coalesce visits each header with one store
// read and one merge or advance step.
// After reset, and after every write of cfg_wdata_i through cfg_we_i, the store is
// reformatted by a clearing pass over all 1024 words, one word per cycle, during which req_i
// is held not ready. Configuration writes must be made only while no command is in progress.
// If the receiver stalls rsp_o, the result is held in the output register. One more command
// can still be taken, and its result then waits in the engine, which holds req_i not ready
// until the stalled transaction completes.
`timescale 1ns / 1ps

module first_fit_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ffba_pkg::CfgW-1:0] cfg_wdata_i,
  ffba_req_if.sink                  req_i,
  ffba_rsp_if.source                rsp_o
);

  logic [ffba_pkg::CfgW-1:0]   heap_q, heap_d;
  logic                        out_valid_q, out_valid_d;
  ffba_pkg::result_t           out_q, out_d;

  logic [ffba_pkg::WideW-1:0]  total_sum;
  logic [ffba_pkg::WideW-1:0]  total_rnd;
  logic [ffba_pkg::WideW-1:0]  total;
  ffba_pkg::geom_t             geom;
  ffba_pkg::mem_req_t          mem_req;
  logic [ffba_pkg::DataW-1:0]  rdata;
  logic                        res_valid;
  logic                        res_ready;
  ffba_pkg::result_t           res;

  assign total_sum = ffba_pkg::WideW'(heap_q) + ffba_pkg::WideW'(ffba_pkg::HeaderOverhead + 7);
  assign total_rnd = {total_sum[ffba_pkg::WideW-1:3], 3'b000};
  assign total     = (total_rnd > ffba_pkg::CapBytes) ? ffba_pkg::CapBytes : total_rnd;

  assign geom.reformat   = cfg_we_i;
  assign geom.last_word  = ffba_pkg::AddrW'(total[ffba_pkg::AddrW+1:2] -
                                            (ffba_pkg::AddrW+1)'(1));
  assign geom.free_bytes = ffba_pkg::DataW'(total - ffba_pkg::WideW'(8));

  assign heap_d      = cfg_we_i ? cfg_wdata_i : heap_q;
  assign res_ready   = !out_valid_q || rsp_o.ready;
  assign out_valid_d = res_valid || (out_valid_q && !rsp_o.ready);
  assign out_d       = (res_valid && res_ready) ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= ffba_pkg::HeapBytesReset;
      out_valid_q <= 1'b0;
    end else begin
      heap_q      <= heap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.granted         = out_q.granted;
  assign rsp_o.payload_address = out_q.payload_address;

  ffba_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .req_i       (req_i),
    .mem_o       (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  ffba_ram #(
    .Width (ffba_pkg::DataW),
    .Depth (ffba_pkg::HeapWords)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule
